@@ design/cthd_pkg.sv @@
// Shared types, constants and helper functions of the cartridge text section decoder.
`timescale 1ns / 1ps
`default_nettype none

package cthd_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned HOLD_CAP  = 15;
    localparam int unsigned HDR_NUM   = 7;
    localparam int unsigned TRAIL_MAX = 6;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [2:0]         sec_t;
    typedef logic [1:0]         kind_t;
    typedef logic [HDR_NUM-1:0] hmask_t;

    localparam cnt_t   CNT_CAP    = cnt_t'(HOLD_CAP);
    localparam cnt_t   TRAIL_LIM  = cnt_t'(TRAIL_MAX);
    localparam hmask_t MASK_ALL   = '1;

    localparam char_t CH_LF  = 8'h0A;
    localparam char_t CH_CR  = 8'h0D;
    localparam char_t CH_SP  = 8'h20;
    localparam char_t CH_TAB = 8'h09;

    localparam kind_t KIND_DATA    = 2'd0;
    localparam kind_t KIND_SECTION = 2'd1;
    localparam kind_t KIND_END     = 2'd2;

    localparam sec_t SEC_NONE  = 3'd0;
    localparam sec_t SEC_LUA   = 3'd1;
    localparam sec_t SEC_GFX   = 3'd2;
    localparam sec_t SEC_GFF   = 3'd3;
    localparam sec_t SEC_LABEL = 3'd4;
    localparam sec_t SEC_MAP   = 3'd5;
    localparam sec_t SEC_SFX   = 3'd6;
    localparam sec_t SEC_MUSIC = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pay_cur;
        logic pay_held;
        logic hold;
        logic fail;
        logic hdr;
        logic new_line;
        logic replay_inc;
        logic replay_done;
        logic text_end;
        logic fin;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;
        logic pend_v;
        logic yield;
        logic cur_lf;
        logic eot;
        logic failed;
        logic hdr_hit;
        logic cnt_nz;
        logic hold_ok;
        logic replay_last;
    } sts_t;

    // header index i opens section i+1
    function automatic cnt_t hdr_len(input logic [2:0] idx);
        cnt_t len;
        case (idx)
            3'd3, 3'd6: len = 4'd9;
            default:    len = 4'd7;
        endcase
        return len;
    endfunction

    function automatic char_t hdr_char(input logic [2:0] idx, input cnt_t pos);
        logic [9*CHAR_W-1:0] name;
        cnt_t                sel;
        char_t               c;
        case (idx)
            3'd0:    name = "__lua__  ";
            3'd1:    name = "__gfx__  ";
            3'd2:    name = "__gff__  ";
            3'd3:    name = "__label__";
            3'd4:    name = "__map__  ";
            3'd5:    name = "__sfx__  ";
            3'd6:    name = "__music__";
            default: name = '0;
        endcase
        sel = 4'd8 - pos;
        if (pos > 4'd8)
            c = '0;
        else
            c = name[{sel, 3'b000} +: CHAR_W];
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input char_t c);
        logic [4:0] r;
        if (c >= "0" && c <= "9")
            r = {1'b1, 4'(c - "0")};
        else if (c >= "a" && c <= "f")
            r = {1'b1, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F")
            r = {1'b1, 4'(c - "A" + 8'd10)};
        else
            r = 5'd0;
        return r;
    endfunction

    function automatic logic is_ws(input char_t c);
        return (c == CH_CR) || (c == CH_SP) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

@@ design/cthd_in_if.sv @@
// Input word channel: one text character and its end-of-text mark.
`timescale 1ns / 1ps
`default_nettype none

interface cthd_in_if;
    import cthd_pkg::*;

    logic  valid;
    logic  ready;
    char_t ch;
    logic  end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ design/cthd_out_if.sv @@
// Output word channel: one decoded result.
`timescale 1ns / 1ps
`default_nettype none

interface cthd_out_if;
    import cthd_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    sec_t  section;
    char_t value;
    logic  last;

    modport source (output valid, output kind, output section, output value, output last,
                    input ready);
    modport sink   (input valid, input kind, input section, input value, input last,
                    output ready);
endinterface

`default_nettype wire

@@ design/cart_text_section_hex_decoder_unit.sv @@
// Top level of the cartridge text section decoder.
//
// Takes one text character per input word and returns decoded words: data
// nibbles or bytes, section-begins markers and a text-ended marker, with last
// set on the final word caused by each character. A character is taken in the
// idle state and worked in the process state. A line that may still be a
// header keeps up to 15 characters in the hold buffer; when it turns out not
// to be one, the controller replays them one per cycle while the output
// register has room, then works the character that broke the match. End of
// text adds a header check of an unterminated line and the text-ended word,
// and an item ending in two new words needs a flush state to release the
// last. The output register lets the next character be taken while a word
// waits; work stalls only while that register is full.
`timescale 1ns / 1ps
`default_nettype none

module cart_text_section_hex_decoder_unit #(
    parameter int unsigned TRAIL_MAX = cthd_pkg::TRAIL_MAX
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cthd_in_if.sink    din,
    cthd_out_if.source dout
);
    import cthd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cthd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cthd_dp #(
        .TRAIL_MAX (TRAIL_MAX)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (din.ch),
        .in_eot (din.end_of_text),
        .cmd    (cmd),
        .sts    (sts),
        .dout   (dout)
    );

endmodule

`default_nettype wire

@@ design/cthd_dp.sv @@
// Datapath: line hold buffer, header match, payload decode and result staging.
`timescale 1ns / 1ps
`default_nettype none

module cthd_dp #(
    parameter int unsigned TRAIL_MAX = cthd_pkg::TRAIL_MAX
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cthd_pkg::char_t in_ch,
    input  wire logic          in_eot,
    input  wire cthd_pkg::cmd_t  cmd,
    output cthd_pkg::sts_t     sts,
    cthd_out_if.source         dout
);
    import cthd_pkg::*;

    localparam cnt_t WS_LIM = cnt_t'(TRAIL_MAX);

    char_t  in_ch_reg;
    logic   eot_reg;
    sec_t   sec_reg, sec_next;
    logic   hnv_reg, hnv_next;
    logic [3:0] hn_reg, hn_next;
    char_t  held_mem [HOLD_CAP];
    cnt_t   cnt_reg, cnt_next;
    hmask_t mask_reg, mask_next;
    logic   failed_reg, failed_next;
    cnt_t   idx_reg, idx_next;

    logic   pend_v_reg, pend_v_next;
    kind_t  pend_kind_reg;
    sec_t   pend_sec_reg;
    char_t  pend_val_reg;
    logic   out_v_reg, out_v_next;
    kind_t  out_kind_reg;
    sec_t   out_sec_reg;
    char_t  out_val_reg;
    logic   out_last_reg;

    logic   hit;
    sec_t   hit_sec;
    hmask_t mask_adv;
    logic   pay, pay_y, pair_sec, hx_ok;
    char_t  pay_ch, pay_v, held_rd;
    logic [4:0] hx;
    logic   yield, push_pend, push_new;
    kind_t  new_kind;
    sec_t   new_sec;
    char_t  new_val;

    assign held_rd = held_mem[idx_reg];

    // header candidates
    always_comb
    begin
        hit      = 1'b0;
        hit_sec  = SEC_NONE;
        mask_adv = '0;
        for (int i = 0; i < HDR_NUM; i++)
        begin
            if (!hit && mask_reg[i] && (cnt_reg >= hdr_len(3'(i))))
            begin
                hit     = 1'b1;
                hit_sec = sec_t'(i + 1);
            end
            if (cnt_reg < hdr_len(3'(i)))
                mask_adv[i] = mask_reg[i] && (in_ch_reg == hdr_char(3'(i), cnt_reg));
            else
                mask_adv[i] = mask_reg[i] && is_ws(in_ch_reg) && (cnt_reg < CNT_CAP)
                              && ((cnt_reg - hdr_len(3'(i))) < WS_LIM);
        end
    end

    // payload decode
    always_comb
    begin
        pay      = cmd.pay_cur | cmd.pay_held;
        pay_ch   = cmd.pay_held ? held_rd : in_ch_reg;
        hx       = hex_val(pay_ch);
        hx_ok    = hx[4];
        pair_sec = (sec_reg == SEC_GFF) || (sec_reg == SEC_MAP);
        pay_y    = 1'b0;
        pay_v    = '0;
        case (sec_reg)
            SEC_GFX, SEC_LABEL:
            begin
                pay_y = hx_ok;
                pay_v = {4'd0, hx[3:0]};
            end
            SEC_GFF, SEC_MAP:
            begin
                pay_y = hx_ok && hnv_reg;
                pay_v = {hn_reg, hx[3:0]};
            end
            SEC_SFX:
            begin
                pay_y = (pay_ch != CH_CR) && (pay_ch != CH_LF);
                pay_v = pay_ch;
            end
            default:
            begin
                pay_y = 1'b0;
                pay_v = '0;
            end
        endcase
    end

    assign yield = (pay && pay_y) || cmd.hdr || cmd.text_end;

    always_comb
    begin
        if (cmd.text_end)
        begin
            new_kind = KIND_END;
            new_sec  = SEC_NONE;
            new_val  = '0;
        end
        else if (cmd.hdr)
        begin
            new_kind = KIND_SECTION;
            new_sec  = hit_sec;
            new_val  = '0;
        end
        else
        begin
            new_kind = KIND_DATA;
            new_sec  = sec_reg;
            new_val  = pay_v;
        end
    end

    // state next values
    always_comb
    begin
        sec_next    = sec_reg;
        hnv_next    = hnv_reg;
        hn_next     = hn_reg;
        cnt_next    = cnt_reg;
        mask_next   = mask_reg;
        failed_next = failed_reg;
        idx_next    = idx_reg;

        if (pay && pair_sec && hx_ok)
        begin
            if (!hnv_reg)
            begin
                hn_next  = hx[3:0];
                hnv_next = 1'b1;
            end
            else
            begin
                hn_next  = '0;
                hnv_next = 1'b0;
            end
        end
        if (cmd.hold)
        begin
            cnt_next  = cnt_reg + 4'd1;
            mask_next = mask_adv;
        end
        if (cmd.fail)
        begin
            mask_next   = '0;
            failed_next = 1'b1;
        end
        if (cmd.hdr)
        begin
            sec_next = hit_sec;
            hnv_next = 1'b0;
            hn_next  = '0;
            cnt_next = '0;
        end
        if (cmd.replay_done)
            cnt_next = '0;
        if (cmd.new_line)
        begin
            cnt_next    = '0;
            mask_next   = MASK_ALL;
            failed_next = 1'b0;
        end
        if (cmd.text_end)
        begin
            sec_next    = SEC_NONE;
            hnv_next    = 1'b0;
            hn_next     = '0;
            cnt_next    = '0;
            mask_next   = MASK_ALL;
            failed_next = 1'b0;
        end
        if (cmd.accept)
            idx_next = '0;
        else if (cmd.replay_inc)
            idx_next = idx_reg + 4'd1;
    end

    // result staging: the newest word waits in pend until its last flag is known
    assign push_pend = pend_v_reg && (yield || cmd.fin);
    assign push_new  = yield && cmd.fin && !pend_v_reg;

    always_comb
    begin
        pend_v_next = pend_v_reg;
        if (yield && !push_new)
            pend_v_next = 1'b1;
        else if (cmd.fin)
            pend_v_next = 1'b0;
        if (push_pend || push_new)
            out_v_next = 1'b1;
        else if (dout.ready)
            out_v_next = 1'b0;
        else
            out_v_next = out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg    <= SEC_NONE;
            hnv_reg    <= 1'b0;
            hn_reg     <= '0;
            cnt_reg    <= '0;
            mask_reg   <= MASK_ALL;
            failed_reg <= 1'b0;
            idx_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            sec_reg    <= sec_next;
            hnv_reg    <= hnv_next;
            hn_reg     <= hn_next;
            cnt_reg    <= cnt_next;
            mask_reg   <= mask_next;
            failed_reg <= failed_next;
            idx_reg    <= idx_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_ch_reg <= in_ch;
            eot_reg   <= in_eot;
        end
        if (cmd.hold)
            held_mem[cnt_reg] <= in_ch_reg;
        if (yield && !push_new)
        begin
            pend_kind_reg <= new_kind;
            pend_sec_reg  <= new_sec;
            pend_val_reg  <= new_val;
        end
        if (push_pend)
        begin
            out_kind_reg <= pend_kind_reg;
            out_sec_reg  <= pend_sec_reg;
            out_val_reg  <= pend_val_reg;
            out_last_reg <= cmd.fin && !yield;
        end
        else if (push_new)
        begin
            out_kind_reg <= new_kind;
            out_sec_reg  <= new_sec;
            out_val_reg  <= new_val;
            out_last_reg <= 1'b1;
        end
    end

    assign dout.valid   = out_v_reg;
    assign dout.kind    = out_kind_reg;
    assign dout.section = out_sec_reg;
    assign dout.value   = out_val_reg;
    assign dout.last    = out_last_reg;

    assign sts.slot_free   = !out_v_reg || dout.ready;
    assign sts.pend_v      = pend_v_reg;
    assign sts.yield       = yield;
    assign sts.cur_lf      = (in_ch_reg == CH_LF);
    assign sts.eot         = eot_reg;
    assign sts.failed      = failed_reg;
    assign sts.hdr_hit     = hit;
    assign sts.cnt_nz      = (cnt_reg != '0);
    assign sts.hold_ok     = (mask_adv != '0) && (cnt_reg < CNT_CAP);
    assign sts.replay_last = (({1'b0, idx_reg} + 5'd1) == {1'b0, cnt_reg});

    a_failed_no_cand: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (mask_reg == '0))
        else $error("failed line still has header candidates");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (push_pend || push_new) |-> (!out_v_reg || dout.ready))
        else $error("output register overwritten while occupied");

    a_replay_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.replay_inc |-> (idx_reg < cnt_reg))
        else $error("replay index beyond held characters");

endmodule

`default_nettype wire

@@ design/cthd_ctrl.sv @@
// Controller: sequences accept, header check, replay, end-of-text and result flush.
`timescale 1ns / 1ps
`default_nettype none

module cthd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cthd_pkg::sts_t sts,
    output cthd_pkg::cmd_t      cmd
);
    import cthd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROC   = 3'd1;
    localparam logic [2:0] S_REPLAY = 3'd2;
    localparam logic [2:0] S_CUR    = 3'd3;
    localparam logic [2:0] S_CLOSE  = 3'd4;
    localparam logic [2:0] S_END    = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       close_rp_reg, close_rp_next;
    logic       fin_now;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        close_rp_next = close_rp_reg;
        fin_now       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (sts.slot_free)
                begin
                    if (sts.cur_lf)
                    begin
                        if (!sts.failed && sts.hdr_hit)
                        begin
                            cmd.hdr      = 1'b1;
                            cmd.new_line = 1'b1;
                            if (sts.eot)
                                state_next = S_END;
                            else
                                fin_now = 1'b1;
                        end
                        else if (!sts.failed && sts.cnt_nz)
                        begin
                            close_rp_next = 1'b0;
                            state_next    = S_REPLAY;
                        end
                        else
                        begin
                            cmd.new_line = 1'b1;
                            if (sts.eot)
                                state_next = S_END;
                            else
                                fin_now = 1'b1;
                        end
                    end
                    else if (sts.failed)
                    begin
                        cmd.pay_cur = 1'b1;
                        if (sts.eot)
                            state_next = S_END;
                        else
                            fin_now = 1'b1;
                    end
                    else if (sts.hold_ok)
                    begin
                        cmd.hold = 1'b1;
                        if (sts.eot)
                            state_next = S_CLOSE;
                        else
                            fin_now = 1'b1;
                    end
                    else
                    begin
                        cmd.fail = 1'b1;
                        if (sts.cnt_nz)
                        begin
                            close_rp_next = 1'b0;
                            state_next    = S_REPLAY;
                        end
                        else
                        begin
                            cmd.pay_cur = 1'b1;
                            if (sts.eot)
                                state_next = S_END;
                            else
                                fin_now = 1'b1;
                        end
                    end
                end
            end
            S_REPLAY:
            begin
                if (sts.slot_free)
                begin
                    cmd.pay_held   = 1'b1;
                    cmd.replay_inc = 1'b1;
                    if (sts.replay_last)
                    begin
                        cmd.replay_done = 1'b1;
                        state_next      = close_rp_reg ? S_END : S_CUR;
                    end
                end
            end
            S_CUR:
            begin
                if (sts.slot_free)
                begin
                    cmd.pay_cur  = 1'b1;
                    cmd.new_line = sts.cur_lf;
                    if (sts.eot)
                        state_next = S_END;
                    else
                        fin_now = 1'b1;
                end
            end
            S_CLOSE:
            begin
                if (sts.slot_free)
                begin
                    if (sts.hdr_hit)
                    begin
                        cmd.hdr    = 1'b1;
                        state_next = S_END;
                    end
                    else if (sts.cnt_nz)
                    begin
                        close_rp_next = 1'b1;
                        state_next    = S_REPLAY;
                    end
                    else
                        state_next = S_END;
                end
            end
            S_END:
            begin
                if (sts.slot_free)
                begin
                    cmd.text_end = 1'b1;
                    fin_now      = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin_now)
        begin
            cmd.fin    = 1'b1;
            state_next = (sts.yield && sts.pend_v) ? S_FLUSH : S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            close_rp_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            close_rp_reg <= close_rp_next;
        end
    end

    a_flush_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> sts.pend_v)
        else $error("flush state with no staged word");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !sts.pend_v)
        else $error("staged word left behind at item end");

    a_replay_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPLAY) |-> sts.cnt_nz)
        else $error("replay with empty hold buffer");

endmodule

`default_nettype wire
